// File: sv/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared types and constants for the vertex transform and perspective divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vtpd_pkg;

    localparam int NUM_COLS   = 4;
    localparam int NUM_LANES  = 3;
    localparam int COL_W      = 64;
    localparam int COEF_W     = 16;
    localparam int POS_W      = 32;
    localparam int PROD_W     = POS_W + COEF_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int MAG_W      = SUM_W - 1;
    localparam int REM_W      = SUM_W;
    localparam int QUO_W      = 32;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_W = 8'd3;

    localparam logic [COL_W-1:0] COL_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [COL_W-1:0] COL_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [COL_W-1:0] COL_Z_RESET = 64'h0000_0100_0000_0000;
    localparam logic [COL_W-1:0] COL_W_RESET = 64'h0100_0000_0000_0000;

    localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
        logic [15:0]       nlo;
        logic              neg;
        logic              ovf;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_LANES-1:0] lane;
        logic [MAG_W-1:0]      wmag;
        logic                  wzero;
    } item_t;

endpackage

`default_nettype wire

// File: sv/vtpd_if.sv
// ----------------------------------------------------------------------------
// vtpd_if
// Channel interfaces for input points, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vtpd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface vtpd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic        w_was_zero;
    logic        clipped;
    modport source (output valid, out_x, out_y, out_z, w_was_zero, clipped, input ready);
    modport sink (input valid, out_x, out_y, out_z, w_was_zero, clipped, output ready);
endinterface

interface vtpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/vtpd_div_pipe.sv
// ----------------------------------------------------------------------------
// vtpd_div_pipe
// Restoring divider pipeline, one quotient bit per stage for three lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vtpd_div_pipe
    import vtpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  item_t      in_item,
    output logic       out_valid,
    output item_t      out_item
);

    item_t              item_reg [1:QUO_W];
    logic [QUO_W:1]     valid_reg;

    genvar j;
    generate
        for (j = 0; j < QUO_W; j++) begin : g_stage
            localparam int BIT  = QUO_W - 1 - j;
            localparam int NSEL = (BIT >= 16) ? BIT - 16 : 0;
            item_t item_src;
            logic  valid_src;
            item_t item_next;

            if (j == 0) begin : g_first
                assign item_src  = in_item;
                assign valid_src = in_valid;
            end else begin : g_rest
                assign item_src  = item_reg[j];
                assign valid_src = valid_reg[j];
            end

            always_comb
            begin
                logic [REM_W-1:0] trial;
                logic [REM_W-1:0] dvs;
                logic             dbit;
                logic             ge;
                item_next = item_src;
                dvs = {1'b0, item_src.wmag};
                for (int k = 0; k < NUM_LANES; k++)
                begin
                    dbit  = (BIT >= 16) ? item_src.lane[k].nlo[NSEL] : 1'b0;
                    trial = {item_src.lane[k].rem[REM_W-2:0], dbit};
                    ge    = (trial >= dvs);
                    item_next.lane[k].rem = ge ? (trial - dvs) : trial;
                    if (!item_src.wzero)
                    begin
                        item_next.lane[k].quo[BIT] = ge;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[j+1] <= valid_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    item_reg[j+1] <= item_next;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W];
    assign out_item  = item_reg[QUO_W];

endmodule

`default_nettype wire

// File: sv/vertex_transform_perspective_divide_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_top
// Transforms a Q16.16 point by a Q8.8 4x4 matrix and divides by w.
// ----------------------------------------------------------------------------
// The block accepts one point per cycle unless the pipeline is halted and
// returns one result word per point through 36 register stages: one stage of
// multipliers, one of column sums, one that forms magnitudes and checks for
// quotient overflow, 32 stages of the restoring divider (one quotient bit each)
// and the output register. The whole pipeline halts while a result word waits
// on the output. Register writes are taken in any cycle but must only be issued
// while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_perspective_divide_top
    import vtpd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vtpd_in_if.sink     in_vtx,
    vtpd_out_if.source  out_vtx,
    vtpd_cfg_if.sink    cfg
);

    logic [COL_W-1:0]          col_reg [NUM_COLS];
    logic                      en;
    logic signed [PROD_W-1:0]  prod_reg [NUM_COLS][NUM_LANES];
    logic signed [SUM_W-1:0]   sum_reg [NUM_COLS];
    logic                      v1_reg, v2_reg, v3_reg;
    item_t                     prep_reg, prep_next;
    logic                      div_valid;
    item_t                     div_item;
    logic                      out_v_reg;
    logic [QUO_W-1:0]          res_reg [NUM_LANES];
    logic [QUO_W-1:0]          res_next [NUM_LANES];
    logic [NUM_LANES-1:0]      clip_next;
    logic                      wz_reg, clip_reg;

    assign cfg.ready = 1'b1;
    assign en        = !out_v_reg || out_vtx.ready;
    assign in_vtx.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg[0] <= COL_X_RESET;
            col_reg[1] <= COL_Y_RESET;
            col_reg[2] <= COL_Z_RESET;
            col_reg[3] <= COL_W_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_COL_X: col_reg[0] <= cfg.data;
                CFG_COL_Y: col_reg[1] <= cfg.data;
                CFG_COL_Z: col_reg[2] <= cfg.data;
                CFG_COL_W: col_reg[3] <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_vtx.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_v_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_reg[c][0] <= $signed(in_vtx.pos_x) * $signed(col_reg[c][15:0]);
                prod_reg[c][1] <= $signed(in_vtx.pos_y) * $signed(col_reg[c][31:16]);
                prod_reg[c][2] <= $signed(in_vtx.pos_z) * $signed(col_reg[c][47:32]);
            end
            for (int c = 0; c < NUM_COLS; c++)
            begin
                sum_reg[c] <= SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                            + SUM_W'(prod_reg[c][2])
                            + SUM_W'($signed({col_reg[c][63:48], 16'h0000}));
            end
            prep_reg <= prep_next;
        end
    end

    always_comb
    begin
        logic [SUM_W-1:0] wabs;
        logic [SUM_W-1:0] nabs;
        logic [MAG_W-1:0] nmag;
        logic             nneg;
        logic             wneg;
        wneg = sum_reg[3][SUM_W-1];
        wabs = wneg ? (SUM_W'(0) - sum_reg[3]) : sum_reg[3];
        prep_next.wmag  = wabs[MAG_W-1:0];
        prep_next.wzero = (sum_reg[3] == '0);
        for (int k = 0; k < NUM_LANES; k++)
        begin
            nneg = sum_reg[k][SUM_W-1];
            nabs = nneg ? (SUM_W'(0) - sum_reg[k]) : sum_reg[k];
            nmag = nabs[MAG_W-1:0];
            prep_next.lane[k].nlo = nmag[15:0];
            prep_next.lane[k].rem = REM_W'(nmag[MAG_W-1:16]);
            if (prep_next.wzero)
            begin
                prep_next.lane[k].neg = nneg;
                prep_next.lane[k].quo = nmag[39:8];
                prep_next.lane[k].ovf = |nmag[MAG_W-1:40];
            end
            else
            begin
                prep_next.lane[k].neg = nneg ^ wneg;
                prep_next.lane[k].quo = '0;
                prep_next.lane[k].ovf = ({16'h0000, nmag} >= {wabs[MAG_W-1:0], 16'h0000});
            end
        end
    end

    vtpd_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_item   (prep_reg),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    always_comb
    begin
        lane_t ln;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            ln = div_item.lane[k];
            clip_next[k] = 1'b0;
            if (ln.ovf || (!ln.neg && ln.quo > SAT_POS) || (ln.neg && ln.quo > SAT_NEG))
            begin
                clip_next[k] = 1'b1;
                res_next[k]  = ln.neg ? SAT_NEG : SAT_POS;
            end
            else
            begin
                res_next[k] = ln.neg ? (QUO_W'(0) - ln.quo) : ln.quo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_LANES; k++)
            begin
                res_reg[k] <= res_next[k];
            end
            wz_reg   <= div_item.wzero;
            clip_reg <= |clip_next;
        end
    end

    assign out_vtx.valid      = out_v_reg;
    assign out_vtx.out_x      = res_reg[0];
    assign out_vtx.out_y      = res_reg[1];
    assign out_vtx.out_z      = res_reg[2];
    assign out_vtx.w_was_zero = wz_reg;
    assign out_vtx.clipped    = clip_reg;

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_vtx.ready) |=> ($stable(v1_reg) && $stable(v3_reg)
                                           && $stable(div_valid)))
        else $error("Pipeline valid bits moved during a stall.");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vtx.valid && in_vtx.ready) |=> v1_reg)
        else $error("Accepted point did not enter the first stage.");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && cfg.index == CFG_COL_W) |=> (col_reg[3] == $past(cfg.data)))
        else $error("Write to the w column was not stored.");

endmodule

`default_nettype wire
